/* hdl/lwsta_pkg.sv */
// Shared types, widths and constants for the latency window statistics core.
// No dependencies; lwsta_apb and the core top level refer to this package by scoped names.
package lwsta_pkg;

    localparam int DUR_W       = 24;
    localparam int THR_W       = 24;
    localparam int CNT_OUT_W   = 8;
    localparam int PERMILLE_W  = 10;
    localparam int OVR_W       = 32;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 3;

    localparam int WINDOW_DEPTH_DEF = 128;
    localparam int PERMILLE_SCALE   = 1000;

    localparam logic [THR_W-1:0] OVERRUN_THR_RST = 24'd1000;
    localparam logic [THR_W-1:0] SLOW_THR_RST    = 24'd500;

    // operation codes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_OVERRUN_THR = 1'b0;
    localparam logic REG_SLOW_THR    = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [DUR_W-1:0]  elapsed_us;
        logic              on_time;
    } t_in_item;

    typedef struct packed {
        logic [DUR_W-1:0]      average_us;
        logic [DUR_W-1:0]      maximum_us;
        logic [DUR_W-1:0]      minimum_us;
        logic [CNT_OUT_W-1:0]  valid_count;
        logic [PERMILLE_W-1:0] on_time_permille;
        logic                  slow_flag;
        logic [OVR_W-1:0]      overrun_total;
    } t_out_item;

    typedef struct packed {
        logic [THR_W-1:0] overrun_thr;
        logic [THR_W-1:0] slow_thr;
    } t_cfg;

endpackage

/* hdl/lwsta_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters; instantiated by the core top level.
module lwsta_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quot,
    output logic             o_done
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_quot;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_steps;
    logic              r_done;

    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic           w_fits;

    always_comb begin
        w_trial = {r_rem, r_quot[NUM_W-1]};
        w_fits  = w_trial >= {1'b0, r_den};
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quot  <= i_num;
                r_rem   <= '0;
                r_den   <= i_den;
                r_steps <= STEP_W'(NUM_W);
            end else if (r_steps != '0) begin
                // shift in the next dividend bit, subtract when it fits
                r_quot  <= {r_quot[NUM_W-2:0], w_fits};
                r_rem   <= w_fits ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_steps <= r_steps - STEP_W'(1);
                if (r_steps == STEP_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

/* hdl/lwsta_apb.sv */
// APB-style configuration registers: overrun and slow-average thresholds.
// Depends on lwsta_pkg for widths, reset values and register indexes.
module lwsta_apb (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lwsta_pkg::PADDR_W-1:0]  paddr,
    input  logic [lwsta_pkg::DATA_W-1:0]   pwdata,
    output logic [lwsta_pkg::DATA_W-1:0]   prdata,
    output logic                           pready,
    output lwsta_pkg::t_cfg                o_cfg
);

    lwsta_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.overrun_thr <= lwsta_pkg::OVERRUN_THR_RST;
            r_cfg.slow_thr    <= lwsta_pkg::SLOW_THR_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                lwsta_pkg::REG_OVERRUN_THR: begin
                    r_cfg.overrun_thr <= pwdata[lwsta_pkg::THR_W-1:0];
                end
                lwsta_pkg::REG_SLOW_THR: begin
                    r_cfg.slow_thr <= pwdata[lwsta_pkg::THR_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            lwsta_pkg::REG_OVERRUN_THR: prdata = lwsta_pkg::DATA_W'(r_cfg.overrun_thr);
            lwsta_pkg::REG_SLOW_THR:    prdata = lwsta_pkg::DATA_W'(r_cfg.slow_thr);
            default:                    prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

/* hdl/latency_window_statistics_core.sv */
// Latency window statistics core: top level with ring memory, scan and sequencer.
// Depends on lwsta_pkg, lwsta_apb (configuration) and lwsta_div (shared divider).
//
// Usage:
//   Command channel: an item beat (i_item) is taken at a rising edge with start high
//   and busy low. A record beat (operation = record) writes duration and on-time flag
//   into the next ring slot and bumps the overrun count when the duration is above
//   the overrun threshold; it gives no result.
//   A report beat scans every ring slot (zero durations are empty) and then runs two
//   divisions on one shared divider: sum / count, then on-time * 1000 / count.
//   Report: busy stays high through the scan, both divisions and the sequencing states;
//   the strobe is registered and comes with the return to idle, so the next beat can be
//   taken while the strobe is high. With an empty window the divisions are skipped.
//   Result channel: o_result is valid for exactly one cycle, marked by o_result_valid.
//   The receiver cannot stall it; the core holds busy until that strobe is issued.
//   Configuration: APB-style writes at byte 0 (overrun threshold) and 4 (slow
//   average threshold); write only while the core is idle.
//   Reset: synchronous, active low. After reset a clearing pass zeroes the ring, one
//   slot per cycle; busy is high meanwhile.
module latency_window_statistics_core #(
    parameter int WINDOW_DEPTH = lwsta_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  lwsta_pkg::t_in_item            i_item,
    // result channel
    output lwsta_pkg::t_out_item           o_result,
    output logic                           o_result_valid,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lwsta_pkg::PADDR_W-1:0]  paddr,
    input  logic [lwsta_pkg::DATA_W-1:0]   pwdata,
    output logic [lwsta_pkg::DATA_W-1:0]   prdata,
    output logic                           pready
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SW    = lwsta_pkg::DUR_W + AW;
    localparam int DUR_W = lwsta_pkg::DUR_W;

    localparam logic [CW-1:0] LAST_IDX  = CW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_POS  = AW'(WINDOW_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_PERM_GO,
        ST_PERM_WAIT
    } t_state;

    t_state                       r_state;
    logic [CW-1:0]                r_cnt;
    logic [AW-1:0]                r_wr_pos;
    logic [lwsta_pkg::OVR_W-1:0]  r_overruns;
    logic [SW-1:0]                r_sum;
    logic [DUR_W-1:0]             r_max;
    logic [DUR_W-1:0]             r_min;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                r_okc;
    logic [DUR_W-1:0]             r_avg;
    lwsta_pkg::t_out_item         r_result;
    logic                         r_result_valid;

    // ring memory: on-time flag above the duration
    logic [DUR_W:0]               r_window [WINDOW_DEPTH];
    logic [DUR_W:0]               r_rd_data;

    lwsta_pkg::t_cfg              w_cfg;
    logic                         w_accept;
    logic                         w_record;
    logic                         w_report;
    logic [DUR_W-1:0]             w_rd_dur;
    logic                         w_rd_ok;
    logic                         w_rd_live;
    logic                         w_div_start;
    logic [SW-1:0]                w_div_num;
    logic [SW-1:0]                w_quot;
    logic                         w_div_done;

    lwsta_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_record = w_accept && (i_item.operation == lwsta_pkg::OP_RECORD);
    assign w_report = w_accept && (i_item.operation == lwsta_pkg::OP_REPORT);

    // Memory: zero during the clearing pass, write on a record beat,
    // read one slot per cycle for the scan.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_window[r_cnt[AW-1:0]] <= '0;
        end else if (w_record) begin
            r_window[r_wr_pos] <= {i_item.on_time, i_item.elapsed_us};
        end
        if (r_cnt < DEPTH_CNT) begin
            r_rd_data <= r_window[r_cnt[AW-1:0]];
        end
    end

    // Data read at count k arrives at count k+1; zero durations are empty slots.
    assign w_rd_dur  = r_rd_data[DUR_W-1:0];
    assign w_rd_ok   = r_rd_data[DUR_W];
    assign w_rd_live = (r_state == ST_SCAN) && (r_cnt != '0) && (w_rd_dur != '0);

    // One divider serves both the average and the on-time share.
    assign w_div_start = (r_state == ST_AVG_GO && r_count != '0) || (r_state == ST_PERM_GO);
    assign w_div_num   = (r_state == ST_AVG_GO) ? r_sum
                       : SW'(r_okc) * SW'(lwsta_pkg::PERMILLE_SCALE);

    lwsta_div #(
        .NUM_W (SW),
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_count),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_cnt          <= '0;
            r_wr_pos       <= '0;
            r_overruns     <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    // sweep the ring once after reset
                    if (r_cnt == LAST_IDX) begin
                        r_cnt   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                ST_IDLE: begin
                    if (w_record) begin
                        // advance and wrap the write position
                        r_wr_pos <= (r_wr_pos == LAST_POS) ? '0 : r_wr_pos + AW'(1);
                        if (i_item.elapsed_us > w_cfg.overrun_thr) begin
                            r_overruns <= r_overruns + lwsta_pkg::OVR_W'(1);
                        end
                    end
                    if (w_report) begin
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_max   <= '0;
                        r_min   <= '1;
                        r_count <= '0;
                        r_okc   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_rd_live) begin
                        r_sum   <= r_sum + SW'(w_rd_dur);
                        r_count <= r_count + CW'(1);
                        r_okc   <= r_okc + CW'(w_rd_ok);
                        if (w_rd_dur > r_max) begin
                            r_max <= w_rd_dur;
                        end
                        if (w_rd_dur < r_min) begin
                            r_min <= w_rd_dur;
                        end
                    end
                    if (r_cnt == DEPTH_CNT) begin
                        r_state <= ST_AVG_GO;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                ST_AVG_GO: begin
                    if (r_count == '0) begin
                        // empty window: drop the divisions, report zeros and the overrun total
                        r_result.average_us       <= '0;
                        r_result.maximum_us       <= '0;
                        r_result.minimum_us       <= '0;
                        r_result.valid_count      <= '0;
                        r_result.on_time_permille <= '0;
                        r_result.slow_flag        <= 1'b0;
                        r_result.overrun_total    <= r_overruns;
                        r_result_valid            <= 1'b1;
                        r_state                   <= ST_IDLE;
                    end else begin
                        r_state <= ST_AVG_WAIT;
                    end
                end
                ST_AVG_WAIT: begin
                    if (w_div_done) begin
                        r_avg   <= w_quot[DUR_W-1:0];
                        r_state <= ST_PERM_GO;
                    end
                end
                ST_PERM_GO: begin
                    r_state <= ST_PERM_WAIT;
                end
                ST_PERM_WAIT: begin
                    if (w_div_done) begin
                        r_result.average_us       <= r_avg;
                        r_result.maximum_us       <= r_max;
                        r_result.minimum_us       <= r_min;
                        r_result.valid_count      <= lwsta_pkg::CNT_OUT_W'(r_count);
                        r_result.on_time_permille <= w_quot[lwsta_pkg::PERMILLE_W-1:0];
                        r_result.slow_flag        <= (r_avg > w_cfg.slow_thr);
                        r_result.overrun_total    <= r_overruns;
                        r_result_valid            <= 1'b1;
                        r_state                   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_result       = r_result;
    assign o_result_valid = r_result_valid;

`ifndef SYNTHESIS
    // an empty window must give a zero average, a zero maximum and no slow flag
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && r_count == '0) |->
        (o_result.average_us == '0 && o_result.slow_flag == 1'b0 && o_result.maximum_us == '0))
        else $error("empty window report carries nonzero statistics");

    // a record beat must move the write position
    a_wr_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_record |=> (r_wr_pos != $past(r_wr_pos)))
        else $error("write position did not advance on a record beat");

    // a report beat must hold the core busy
    a_report_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_report |=> busy)
        else $error("core not busy after a report beat");

    // maximum never below minimum in a reported window
    a_max_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.maximum_us >= o_result.minimum_us))
        else $error("reported maximum below minimum");

    // on-time share bounded by one thousand
    a_permille: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.on_time_permille <= 10'd1000))
        else $error("on-time share above one thousand");
`endif

endmodule
